FILE: hdl/conv3x3_zero_padded_macros.svh
// ----------------------------------------------------------------------------
// conv3x3_zero_padded assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_ZERO_PADDED_MACROS_SVH
`define CONV3X3_ZERO_PADDED_MACROS_SVH

// same-cycle implication
`define C3ZP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define C3ZP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/c3zp_pkg.sv
// ----------------------------------------------------------------------------
// c3zp_pkg
// Image geometry, widths, register indexes and transaction types.
// ----------------------------------------------------------------------------
package c3zp_pkg;

	localparam int IMAGE_ROWS   = 64;
	localparam int IMAGE_COLS   = 64;
	localparam int SAMPLE_WIDTH = 16;

	localparam int COEF_W  = 16;
	localparam int PROD_W  = SAMPLE_WIDTH + COEF_W;
	localparam int PART_W  = PROD_W + 2;
	localparam int VALUE_W = 36;
	localparam int REG_W   = 3 * COEF_W;
	localparam int TAPS    = 9;

	localparam int COL_W     = $clog2(IMAGE_COLS);
	localparam int ROW_W     = $clog2(IMAGE_ROWS + 1);
	localparam int OUT_ROW_W = $clog2(IMAGE_ROWS);

	localparam int MQ_DEPTH = 4;
	localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
	localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
	localparam int CRED_W   = OQ_CNT_W + 1;

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_TOP    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIDDLE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BOTTOM = 2'd2;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]       coef_t;
	typedef logic signed [PROD_W-1:0]       prod_t;
	typedef logic signed [PART_W-1:0]       part_t;
	typedef logic signed [VALUE_W-1:0]      value_t;

	typedef struct packed {
		logic    kind;
		sample_t sample;
	} pixel_t;

	typedef struct packed {
		value_t value;
		logic   frame_end;
	} result_t;

	// tap index is row * 3 + column, top left first
	typedef struct packed {
		sample_t [TAPS-1:0] tap;
		logic               frame_end;
	} tap_item_t;

	typedef struct packed {
		logic      valid;
		tap_item_t item;
	} tap_push_t;

	function automatic coef_t coef_of(input logic [REG_W-1:0] row, input int unsigned j);
		coef_of = $signed(row[j*COEF_W +: COEF_W]);
	endfunction

endpackage

FILE: hdl/c3zp_ram.sv
// ----------------------------------------------------------------------------
// c3zp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c3zp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/c3zp_front.sv
// ----------------------------------------------------------------------------
// c3zp_front
// Accepts pixel and drain transactions, tracks raster position, runs the two
// line stores and the 3x3 window, and hands masked tap sets to the back end.
// ----------------------------------------------------------------------------
module c3zp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  c3zp_pkg::pixel_t    pixel,
	input  logic                room,
	output c3zp_pkg::tap_push_t tap_push
);

	logic [c3zp_pkg::ROW_W-1:0]     in_row_q;
	logic [c3zp_pkg::COL_W-1:0]     in_col_q;
	logic [c3zp_pkg::OUT_ROW_W-1:0] out_row_q;
	logic [c3zp_pkg::COL_W-1:0]     out_col_q;

	logic accept;
	logic is_drain;
	logic frame_full;
	logic take;
	logic emit;
	logic last_out;
	logic in_col_last;
	logic out_col_last;
	logic [2:0] row_ok;
	logic [2:0] col_ok;
	logic [c3zp_pkg::TAPS-1:0] mask_d;

	logic                       valid_s1;
	logic                       emit_s1;
	logic                       fe_s1;
	logic [c3zp_pkg::COL_W-1:0] col_s1;
	c3zp_pkg::sample_t          sample_s1;
	logic [c3zp_pkg::TAPS-1:0]  mask_s1;

	c3zp_pkg::sample_t top_rd;
	c3zp_pkg::sample_t mid_rd;
	c3zp_pkg::sample_t new_col [3];
	c3zp_pkg::sample_t win_q [3][3];

	assign full       = !room;
	assign accept     = push && !full;
	assign is_drain   = pixel.kind == c3zp_pkg::KIND_DRAIN;
	assign frame_full = in_row_q >= c3zp_pkg::ROW_W'(c3zp_pkg::IMAGE_ROWS);
	assign take       = accept && (is_drain == frame_full);

	assign emit = (in_row_q >= c3zp_pkg::ROW_W'(2)) ||
		(in_row_q == c3zp_pkg::ROW_W'(1) && in_col_q != '0);

	assign in_col_last  = in_col_q == c3zp_pkg::COL_W'(c3zp_pkg::IMAGE_COLS - 1);
	assign out_col_last = out_col_q == c3zp_pkg::COL_W'(c3zp_pkg::IMAGE_COLS - 1);
	assign last_out = out_col_last &&
		out_row_q == c3zp_pkg::OUT_ROW_W'(c3zp_pkg::IMAGE_ROWS - 1);

	assign row_ok = {out_row_q != c3zp_pkg::OUT_ROW_W'(c3zp_pkg::IMAGE_ROWS - 1), 1'b1,
		out_row_q != '0};
	assign col_ok = {!out_col_last, 1'b1, out_col_q != '0};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				mask_d[i*3 + j] = row_ok[i] && col_ok[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			valid_s1  <= 1'b0;
			emit_s1   <= 1'b0;
		end else begin
			valid_s1 <= take;
			emit_s1  <= take && emit;
			if (take) begin
				if (emit && last_out) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
				end else begin
					if (in_col_last) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + c3zp_pkg::ROW_W'(1);
					end else begin
						in_col_q <= in_col_q + c3zp_pkg::COL_W'(1);
					end
					if (emit) begin
						if (out_col_last) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + c3zp_pkg::OUT_ROW_W'(1);
						end else begin
							out_col_q <= out_col_q + c3zp_pkg::COL_W'(1);
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fe_s1     <= emit && last_out;
			col_s1    <= in_col_q;
			sample_s1 <= is_drain ? '0 : pixel.sample;
			mask_s1   <= mask_d;
		end
	end

	// older store feeds the top window row, newer store the middle row
	c3zp_ram #(
		.WIDTH(c3zp_pkg::SAMPLE_WIDTH),
		.DEPTH(c3zp_pkg::IMAGE_COLS)
	) u_older (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (mid_rd),
		.re    (take),
		.raddr (in_col_q),
		.rdata (top_rd)
	);

	c3zp_ram #(
		.WIDTH(c3zp_pkg::SAMPLE_WIDTH),
		.DEPTH(c3zp_pkg::IMAGE_COLS)
	) u_newer (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (sample_s1),
		.re    (take),
		.raddr (in_col_q),
		.rdata (mid_rd)
	);

	assign new_col[0] = top_rd;
	assign new_col[1] = mid_rd;
	assign new_col[2] = sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				if (fe_s1) begin
					win_q[i][0] <= '0;
					win_q[i][1] <= '0;
					win_q[i][2] <= '0;
				end else begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
					win_q[i][2] <= new_col[i];
				end
			end
		end
	end

	// taps of the shifted window, zeroed outside the image
	always_comb begin
		tap_push = '0;
		tap_push.valid = emit_s1;
		tap_push.item.frame_end = fe_s1;
		for (int i = 0; i < 3; i++) begin
			tap_push.item.tap[i*3 + 0] = mask_s1[i*3 + 0] ? win_q[i][1] : '0;
			tap_push.item.tap[i*3 + 1] = mask_s1[i*3 + 1] ? win_q[i][2] : '0;
			tap_push.item.tap[i*3 + 2] = mask_s1[i*3 + 2] ? new_col[i] : '0;
		end
	end

endmodule

FILE: hdl/c3zp_back.sv
// ----------------------------------------------------------------------------
// c3zp_back
// Tap queue, kernel registers, multiply and adder-tree pipeline, and the
// result queue.
// ----------------------------------------------------------------------------
module c3zp_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  c3zp_pkg::tap_push_t                tap_push,
	output logic                               room,
	input  logic                               wr_en,
	input  logic [c3zp_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [c3zp_pkg::REG_W-1:0]         wr_data,
	output logic                               empty,
	input  logic                               pop,
	output c3zp_pkg::result_t                  result
);

	logic [c3zp_pkg::REG_W-1:0] kernel_q [3];

	c3zp_pkg::tap_item_t           mq_q [c3zp_pkg::MQ_DEPTH];
	logic [c3zp_pkg::MQ_PTR_W-1:0] mq_wr_q;
	logic [c3zp_pkg::MQ_PTR_W-1:0] mq_rd_q;
	logic [c3zp_pkg::MQ_CNT_W-1:0] mq_cnt_q;
	c3zp_pkg::tap_item_t           mq_head;
	logic                          mq_pop;

	c3zp_pkg::result_t             oq_q [c3zp_pkg::OQ_DEPTH];
	logic [c3zp_pkg::OQ_PTR_W-1:0] oq_wr_q;
	logic [c3zp_pkg::OQ_PTR_W-1:0] oq_rd_q;
	logic [c3zp_pkg::OQ_CNT_W-1:0] oq_cnt_q;
	logic                          oq_pop;
	logic [c3zp_pkg::CRED_W-1:0]   committed;
	logic                          credit;

	c3zp_pkg::prod_t prod_d  [c3zp_pkg::TAPS];
	c3zp_pkg::prod_t prod_s2 [c3zp_pkg::TAPS];
	logic            valid_s2;
	logic            fe_s2;
	c3zp_pkg::part_t part_s3 [3];
	logic            valid_s3;
	logic            fe_s3;
	c3zp_pkg::value_t sum_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				kernel_q[r] <= '0;
			end
		end else if (wr_en) begin
			case (wr_index)
				c3zp_pkg::REG_TOP: begin
					kernel_q[0] <= wr_data;
				end
				c3zp_pkg::REG_MIDDLE: begin
					kernel_q[1] <= wr_data;
				end
				c3zp_pkg::REG_BOTTOM: begin
					kernel_q[2] <= wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	// tap queue; the front holds off while fewer than two slots are free
	assign room    = mq_cnt_q <= c3zp_pkg::MQ_CNT_W'(c3zp_pkg::MQ_DEPTH - 2);
	assign mq_head = mq_q[mq_rd_q];

	assign committed = c3zp_pkg::CRED_W'(oq_cnt_q) + c3zp_pkg::CRED_W'(valid_s2) +
		c3zp_pkg::CRED_W'(valid_s3);
	assign credit = committed < c3zp_pkg::CRED_W'(c3zp_pkg::OQ_DEPTH);
	assign mq_pop = (mq_cnt_q != '0) && credit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mq_wr_q  <= '0;
			mq_rd_q  <= '0;
			mq_cnt_q <= '0;
		end else begin
			if (tap_push.valid) begin
				mq_wr_q <= mq_wr_q + c3zp_pkg::MQ_PTR_W'(1);
			end
			if (mq_pop) begin
				mq_rd_q <= mq_rd_q + c3zp_pkg::MQ_PTR_W'(1);
			end
			mq_cnt_q <= mq_cnt_q + c3zp_pkg::MQ_CNT_W'(tap_push.valid) -
				c3zp_pkg::MQ_CNT_W'(mq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (tap_push.valid) begin
			mq_q[mq_wr_q] <= tap_push.item;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int j = 0; j < 3; j++) begin
				prod_d[r*3 + j] = c3zp_pkg::prod_t'($signed(mq_head.tap[r*3 + j])) *
					c3zp_pkg::prod_t'(c3zp_pkg::coef_of(kernel_q[r], j));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= mq_pop;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (mq_pop) begin
			prod_s2 <= prod_d;
			fe_s2   <= mq_head.frame_end;
		end
		if (valid_s2) begin
			for (int r = 0; r < 3; r++) begin
				part_s3[r] <= c3zp_pkg::part_t'(prod_s2[r*3]) +
					c3zp_pkg::part_t'(prod_s2[r*3 + 1]) +
					c3zp_pkg::part_t'(prod_s2[r*3 + 2]);
			end
			fe_s3 <= fe_s2;
		end
	end

	assign sum_d = c3zp_pkg::value_t'(part_s3[0]) + c3zp_pkg::value_t'(part_s3[1]) +
		c3zp_pkg::value_t'(part_s3[2]);

	// result queue
	assign empty  = oq_cnt_q == '0;
	assign oq_pop = pop && !empty;
	assign result = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (valid_s3) begin
				oq_wr_q <= oq_wr_q + c3zp_pkg::OQ_PTR_W'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + c3zp_pkg::OQ_PTR_W'(1);
			end
			oq_cnt_q <= oq_cnt_q + c3zp_pkg::OQ_CNT_W'(valid_s3) -
				c3zp_pkg::OQ_CNT_W'(oq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			oq_q[oq_wr_q].value     <= sum_d;
			oq_q[oq_wr_q].frame_end <= fe_s3;
		end
	end

endmodule

FILE: hdl/conv3x3_zero_padded.sv
// ----------------------------------------------------------------------------
// conv3x3_zero_padded - 3x3 zero-padded convolution over a raster image
// A result passes s1, the tap queue, s2, s3 and the result queue after the
// transaction completing its window (the pixel one row and one column later).
// Throughput: one transaction per cycle in and out when not full or stalled,
// set by one line-store access per pixel and one window shift per pixel.
// Reset clears position counters, window, kernel registers and both queues.
// ----------------------------------------------------------------------------
module conv3x3_zero_padded (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  c3zp_pkg::pixel_t               pixel,
	output logic                           empty,
	input  logic                           pop,
	output c3zp_pkg::result_t              result,
	input  logic                           wr_en,
	input  logic [c3zp_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [c3zp_pkg::REG_W-1:0]     wr_data
);

	c3zp_pkg::tap_push_t tap_push;
	logic                room;

	c3zp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pixel    (pixel),
		.room     (room),
		.tap_push (tap_push)
	);

	c3zp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tap_push (tap_push),
		.room     (room),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

FILE: hdl/c3zp_checker.sv
// ----------------------------------------------------------------------------
// c3zp_checker
// Port-level checks for conv3x3_zero_padded, bound to the top level.
// ----------------------------------------------------------------------------
`include "conv3x3_zero_padded_macros.svh"

module c3zp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input c3zp_pkg::result_t result
);

	`C3ZP_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result), "waiting result changed")

	`C3ZP_ASSERT_NOW(a_reset_idle, $rose(arst_n), empty && !full, "not idle after reset")

	`C3ZP_ASSERT_NEXT(a_full_quiet, !full && !(push && !full) && !$past(push && !full), !full, "full rose with no transaction in flight")

endmodule

bind conv3x3_zero_padded c3zp_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

FILE: verif/conv3x3_zero_padded_tb.sv
// ----------------------------------------------------------------------------
// conv3x3_zero_padded_tb - self-checking bench for the 3x3 zero-padded filter
// A clocked driver pushes pixel and drain transactions from a planned stream,
// with kernel writes between quiet phases. A clocked monitor pops results and
// compares them with a local model of the line stores, window and padding.
// Both sides insert random gaps between transactions, with stretches without gaps.
// ----------------------------------------------------------------------------
module conv3x3_zero_padded_tb;
	import c3zp_pkg::*;

	localparam int SETTLE_CYCLES = 12;
	localparam int FRAME_PIXELS  = IMAGE_ROWS * IMAGE_COLS;

	typedef enum logic [1:0] {STEP_PIXEL, STEP_WRITE, STEP_QUIESCE} step_kind_e;

	typedef struct {
		step_kind_e             kind;
		pixel_t                 pix;
		logic [REG_IDX_W-1:0]   idx;
		logic [REG_W-1:0]       data;
	} plan_step_t;

	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 push     = 1'b0;
	logic                 full;
	pixel_t               pixel    = '0;
	logic                 empty;
	logic                 pop      = 1'b0;
	result_t              result;
	logic                 wr_en    = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = REG_TOP;
	logic [REG_W-1:0]     wr_data  = '0;

	plan_step_t stim_plan[$];
	result_t    filtered_queue[$];
	int         mismatches = 0;

	// filter model state
	logic [REG_W-1:0] kernel_reg [3] = '{default: '0};
	sample_t          older_row [IMAGE_COLS] = '{default: '0};
	sample_t          newer_row [IMAGE_COLS] = '{default: '0};
	sample_t          win [3][3] = '{default: '0};
	int unsigned      in_row = 0;
	int unsigned      in_col = 0;
	int unsigned      emitted = 0;

	// driver and monitor pacing
	int   tx_gap = 0;
	int   rx_stall = 0;
	int   settle = 0;
	bit   tx_calm = 1'b0;
	bit   rx_calm = 1'b0;
	logic drv_push;
	pixel_t drv_pixel;
	logic drv_wr;
	logic [REG_IDX_W-1:0] drv_idx;
	logic [REG_W-1:0] drv_data;
	logic mon_pop;

	logic [REG_IDX_W-1:0] reg_codes [3] = '{REG_TOP, REG_MIDDLE, REG_BOTTOM};

	conv3x3_zero_padded dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pixel    (pixel),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void convolve_pixel(input pixel_t p);
		int unsigned k;
		int unsigned cr;
		int unsigned cc;
		sample_t s;
		sample_t top_s;
		sample_t mid_s;
		logic signed [COEF_W-1:0] cf;
		logic signed [47:0] acc;
		result_t r;
		k = in_row * IMAGE_COLS + in_col;
		if (p.kind == KIND_PIXEL) begin
			if (in_row >= IMAGE_ROWS)
				return;
			s = p.sample;
		end else begin
			if (in_row < IMAGE_ROWS)
				return;
			s = '0;
		end
		top_s = older_row[in_col];
		mid_s = newer_row[in_col];
		older_row[in_col] = mid_s;
		newer_row[in_col] = s;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = top_s;
		win[1][2] = mid_s;
		win[2][2] = s;
		in_col++;
		if (in_col >= IMAGE_COLS) begin
			in_col = 0;
			in_row++;
		end
		if (k < IMAGE_COLS + 1)
			return;
		cr = emitted / IMAGE_COLS;
		cc = emitted % IMAGE_COLS;
		acc = '0;
		for (int i = 0; i < 3; i++) begin
			if (!(i == 0 && cr == 0) && !(i == 2 && cr + 1 >= IMAGE_ROWS)) begin
				for (int j = 0; j < 3; j++) begin
					if (!(j == 0 && cc == 0) && !(j == 2 && cc + 1 >= IMAGE_COLS)) begin
						cf = kernel_reg[i][j*COEF_W +: COEF_W];
						acc = acc + win[i][j] * cf;
					end
				end
			end
		end
		r.value = acc[VALUE_W-1:0];
		emitted++;
		if (emitted >= FRAME_PIXELS) begin
			r.frame_end = 1'b1;
			in_row = 0;
			in_col = 0;
			emitted = 0;
			win = '{default: '0};
		end else begin
			r.frame_end = 1'b0;
		end
		filtered_queue.push_back(r);
	endfunction

	function automatic int draw_wait(ref bit calm);
		if ($urandom_range(0, 149) == 0)
			calm = ~calm;
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			pixel <= '0;
			wr_en <= 1'b0;
			wr_index <= REG_TOP;
			wr_data <= '0;
		end else begin
			drv_push = push;
			drv_pixel = pixel;
			drv_wr = 1'b0;
			drv_idx = wr_index;
			drv_data = wr_data;
			if (push && !full) begin
				convolve_pixel(pixel);
				drv_push = 1'b0;
				tx_gap = draw_wait(tx_calm);
			end
			if (!drv_push && stim_plan.size() != 0) begin
				case (stim_plan[0].kind)
					STEP_PIXEL: begin
						if (tx_gap != 0) begin
							tx_gap = tx_gap - 1;
						end else begin
							drv_push = 1'b1;
							drv_pixel = stim_plan[0].pix;
							void'(stim_plan.pop_front());
						end
					end
					STEP_WRITE: begin
						drv_wr = 1'b1;
						drv_idx = stim_plan[0].idx;
						drv_data = stim_plan[0].data;
						kernel_reg[stim_plan[0].idx] = stim_plan[0].data;
						void'(stim_plan.pop_front());
					end
					default: begin
						if (filtered_queue.size() != 0) begin
							settle = 0;
						end else if (settle < SETTLE_CYCLES) begin
							settle++;
						end else begin
							settle = 0;
							void'(stim_plan.pop_front());
						end
					end
				endcase
			end
			push <= drv_push;
			pixel <= drv_pixel;
			wr_en <= drv_wr;
			wr_index <= drv_idx;
			wr_data <= drv_data;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			mon_pop = pop;
			if (pop && !empty) begin
				if (filtered_queue.size() == 0) begin
					$error("unexpected result transaction: value %0d frame_end %0b",
						result.value, result.frame_end);
					mismatches++;
				end else begin
					if (result.value !== filtered_queue[0].value) begin
						$error("value: expected %0d, got %0d",
							filtered_queue[0].value, result.value);
						mismatches++;
					end
					if (result.frame_end !== filtered_queue[0].frame_end) begin
						$error("frame_end: expected %0b, got %0b",
							filtered_queue[0].frame_end, result.frame_end);
						mismatches++;
					end
					void'(filtered_queue.pop_front());
				end
				mon_pop = 1'b0;
				rx_stall = draw_wait(rx_calm);
			end
			if (!mon_pop) begin
				if (rx_stall != 0)
					rx_stall = rx_stall - 1;
				else
					mon_pop = 1'b1;
			end
			pop <= mon_pop;
		end
	end

	function automatic void plan_item(input logic kind, input logic [15:0] raw);
		plan_step_t st;
		st.kind = STEP_PIXEL;
		st.pix.kind = kind;
		st.pix.sample = raw;
		st.idx = REG_TOP;
		st.data = '0;
		stim_plan.push_back(st);
	endfunction

	function automatic void plan_write(input logic [REG_IDX_W-1:0] idx,
		input logic [REG_W-1:0] data);
		plan_step_t st;
		st.kind = STEP_WRITE;
		st.pix = '0;
		st.idx = idx;
		st.data = data;
		stim_plan.push_back(st);
	endfunction

	function automatic void plan_quiesce();
		plan_step_t st;
		st.kind = STEP_QUIESCE;
		st.pix = '0;
		st.idx = REG_TOP;
		st.data = '0;
		stim_plan.push_back(st);
	endfunction

	function automatic logic [15:0] pick_sample(input int unsigned edge_pct);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < edge_pct / 2)
			return 16'h8000;
		if (roll < edge_pct)
			return 16'h7FFF;
		if (roll < edge_pct + 25)
			return 16'($urandom_range(0, 1023) - 512);
		return 16'($urandom);
	endfunction

	function automatic logic [REG_W-1:0] pick_row();
		logic [REG_W-1:0] row;
		for (int j = 0; j < 3; j++) begin
			case ($urandom_range(0, 5))
				0: row[j*COEF_W +: COEF_W] = 16'h8000;
				1: row[j*COEF_W +: COEF_W] = 16'h7FFF;
				2: row[j*COEF_W +: COEF_W] = 16'h0000;
				3: row[j*COEF_W +: COEF_W] = 16'($urandom_range(0, 15) - 8);
				default: row[j*COEF_W +: COEF_W] = 16'($urandom);
			endcase
		end
		return row;
	endfunction

	// pixel indexes first up to last - 1, then the drain transactions once the
	// frame is complete
	function automatic void plan_frame(input int first, input int last,
		input int unsigned edge_pct);
		int phase_end;
		phase_end = first + $urandom_range(100, 200);
		for (int n = first; n < last; n++) begin
			if (n == phase_end) begin
				plan_quiesce();
				plan_write(reg_codes[$urandom_range(0, 2)], pick_row());
				phase_end += $urandom_range(100, 200);
			end
			plan_item(KIND_PIXEL, pick_sample(edge_pct));
			if ($urandom_range(0, 199) == 0)
				plan_item(KIND_DRAIN, 16'($urandom));
		end
		if (last >= FRAME_PIXELS) begin
			for (int n = 0; n < IMAGE_COLS + 1; n++) begin
				if ($urandom_range(0, 15) == 0)
					plan_item(KIND_PIXEL, 16'($urandom));
				plan_item(KIND_DRAIN, 16'($urandom));
			end
		end
	endfunction

	initial begin
		logic [15:0] edge_pix [13];
		edge_pix = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555,
			16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0100, 16'hFF00};

		// drains before any pixel are ignored
		plan_item(KIND_DRAIN, 16'h0000);
		plan_item(KIND_DRAIN, 16'hFFFF);
		plan_quiesce();
		plan_write(REG_TOP, {3{16'h7FFF}});
		plan_write(REG_MIDDLE, {3{16'h8000}});
		plan_write(REG_BOTTOM, {16'h7FFF, 16'h0001, 16'h8000});
		foreach (edge_pix[i])
			plan_item(KIND_PIXEL, edge_pix[i]);
		plan_item(KIND_DRAIN, 16'h1234);
		plan_frame(13, 300, 20);

		// largest magnitudes: full negative kernel
		plan_quiesce();
		plan_write(REG_TOP, {3{16'h8000}});
		plan_write(REG_MIDDLE, {3{16'h8000}});
		plan_write(REG_BOTTOM, {3{16'h8000}});
		plan_item(KIND_DRAIN, 16'h8000);
		plan_frame(300, 520, 60);

		// zero kernel for a while, then random kernels
		plan_quiesce();
		plan_write(REG_TOP, '0);
		plan_write(REG_MIDDLE, '0);
		plan_write(REG_BOTTOM, '0);
		for (int n = 0; n < 40; n++)
			plan_item(KIND_PIXEL, pick_sample(10));
		plan_quiesce();
		plan_write(REG_TOP, pick_row());
		plan_write(REG_MIDDLE, pick_row());
		plan_write(REG_BOTTOM, pick_row());
		plan_frame(560, 780, 10);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (stim_plan.size() != 0 || push || filtered_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && filtered_queue.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
